// ===== design/sarq_pkg.sv =====
// Shared types, codes and constants of the stop-and-wait ARQ block.
`default_nettype none

package sarq_pkg;

    // Default payload buffer depth
    localparam int MAX_PAYLOAD_DEF = 32;

    // Input item kinds
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Result kinds
    localparam logic [1:0] OUT_FRAME   = 2'd0;
    localparam logic [1:0] OUT_DELIVER = 2'd1;
    localparam logic [1:0] OUT_GAVE_UP = 2'd2;
    localparam logic [1:0] OUT_ACKED   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_RETRIES   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd1;
    localparam logic [2:0] REG_ACK0_CODE     = 3'd2;
    localparam logic [2:0] REG_ACK1_CODE     = 3'd3;
    localparam logic [2:0] REG_MSG_COMMAND   = 3'd4;

    // Configuration reset values
    localparam logic [3:0]  MAX_RETRIES_RST   = 4'd3;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
    localparam logic [7:0]  ACK0_CODE_RST     = 8'h80;
    localparam logic [7:0]  ACK1_CODE_RST     = 8'h88;
    localparam logic [7:0]  MSG_COMMAND_RST   = 8'h00;

    // Data frame control bytes
    localparam logic [7:0] DATA0_CODE = 8'h00;
    localparam logic [7:0] DATA1_CODE = 8'h08;

    // Receive phase codes
    localparam logic [1:0] RX_CTRL    = 2'd0;
    localparam logic [1:0] RX_DELIVER = 2'd1;
    localparam logic [1:0] RX_DISCARD = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CTRL,
        ST_DATA
    } sarq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_ctrl;
        logic emit_data;
    } sarq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic item_valid;
        logic out_free;
        logic frame_req;
        logic len_zero;
        logic last_data;
    } sarq_sts_t;

endpackage

`default_nettype wire

// ===== design/sarq_ctrl.sv =====
// Controller of the stop-and-wait ARQ block: input admission and frame sequencing.
`default_nettype none

module sarq_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sarq_pkg::sarq_sts_t sts,
    output sarq_pkg::sarq_cmd_t     cmd
);

    sarq_pkg::sarq_state_t state_reg;
    sarq_pkg::sarq_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sarq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through idle, control byte and payload bytes
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            sarq_pkg::ST_IDLE:
            begin
                cmd.accept = sts.out_free;
                if (sts.item_valid && sts.out_free && sts.frame_req)
                begin
                    state_next = sarq_pkg::ST_CTRL;
                end
            end
            sarq_pkg::ST_CTRL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ctrl = 1'b1;
                    state_next    = sts.len_zero ? sarq_pkg::ST_IDLE : sarq_pkg::ST_DATA;
                end
            end
            sarq_pkg::ST_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (sts.last_data)
                    begin
                        state_next = sarq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sarq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/sarq_dp.sv =====
// Datapath of the stop-and-wait ARQ block: registers, protocol state, payload store, output.
`default_nettype none

module sarq_dp
#(
    parameter int MAX_PAYLOAD = sarq_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,
    input  wire logic                s_tlast,
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,
    output logic                     m_tlast,
    output logic [1:0]               m_tuser,
    input  wire sarq_pkg::sarq_cmd_t cmd,
    output sarq_pkg::sarq_sts_t      sts
);

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PAYLOAD);

    // Configuration registers
    logic [3:0]  max_retries_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  ack0_code_reg;
    logic [7:0]  ack1_code_reg;
    logic [7:0]  msg_command_reg;

    // Protocol state
    logic          waiting_reg, waiting_next;
    logic          tx_seq_reg, tx_seq_next;
    logic          rx_seq_reg, rx_seq_next;
    logic [3:0]    retry_count_reg, retry_count_next;
    logic          timer_armed_reg, timer_armed_next;
    logic [15:0]   timer_count_reg, timer_count_next;
    logic [LW-1:0] tx_length_reg, tx_length_next;
    logic [7:0]    tx_command_reg, tx_command_next;
    logic [1:0]    rx_phase_reg, rx_phase_next;
    logic [LW-1:0] idx_reg, idx_next;

    // Payload store
    logic [7:0]    mem [MAX_PAYLOAD];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [7:0]    out_cmd_reg, out_cmd_next;
    logic          out_last_reg, out_last_next;

    // Item fields and helpers
    logic [7:0]    in_byte;
    logic [7:0]    in_cmd;
    logic          acc;
    logic          out_free;
    logic          frame_req;
    logic [15:0]   cnt_inc;
    logic [LW-1:0] idx_inc;
    logic [7:0]    good_ack;
    logic [7:0]    bad_ack;
    logic [7:0]    new_data;
    logic [7:0]    old_data;

    assign in_byte  = s_tdata[7:0];
    assign in_cmd   = s_tdata[15:8];
    assign out_free = !out_valid_reg || m_tready;
    assign acc      = s_tvalid && cmd.accept;
    assign s_tready = cmd.accept;
    assign cnt_inc  = (timer_count_reg != 16'hFFFF) ? timer_count_reg + 16'd1 : timer_count_reg;
    assign idx_inc  = idx_reg + LW'(1);
    assign good_ack = tx_seq_reg ? ack1_code_reg : ack0_code_reg;
    assign bad_ack  = tx_seq_reg ? ack0_code_reg : ack1_code_reg;
    assign new_data = rx_seq_reg ? sarq_pkg::DATA1_CODE : sarq_pkg::DATA0_CODE;
    assign old_data = rx_seq_reg ? sarq_pkg::DATA0_CODE : sarq_pkg::DATA1_CODE;

    // Status toward the controller
    assign sts.item_valid = s_tvalid;
    assign sts.out_free   = out_free;
    assign sts.frame_req  = frame_req;
    assign sts.len_zero   = (tx_length_reg == '0);
    assign sts.last_data  = (idx_inc == tx_length_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cmd_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg   <= sarq_pkg::MAX_RETRIES_RST;
            timeout_ticks_reg <= sarq_pkg::TIMEOUT_TICKS_RST;
            ack0_code_reg     <= sarq_pkg::ACK0_CODE_RST;
            ack1_code_reg     <= sarq_pkg::ACK1_CODE_RST;
            msg_command_reg   <= sarq_pkg::MSG_COMMAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sarq_pkg::REG_MAX_RETRIES:   max_retries_reg   <= cfg_data[3:0];
                sarq_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                sarq_pkg::REG_ACK0_CODE:     ack0_code_reg     <= cfg_data[7:0];
                sarq_pkg::REG_ACK1_CODE:     ack1_code_reg     <= cfg_data[7:0];
                sarq_pkg::REG_MSG_COMMAND:   msg_command_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Process one accepted item and the frame emission steps
    always_comb
    begin
        waiting_next     = waiting_reg;
        tx_seq_next      = tx_seq_reg;
        rx_seq_next      = rx_seq_reg;
        retry_count_next = retry_count_reg;
        timer_armed_next = timer_armed_reg;
        timer_count_next = timer_count_reg;
        tx_length_next   = tx_length_reg;
        tx_command_next  = tx_command_reg;
        rx_phase_next    = rx_phase_reg;
        idx_next         = idx_reg;
        mem_we           = 1'b0;
        frame_req        = 1'b0;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_byte_next    = out_byte_reg;
        out_cmd_next     = out_cmd_reg;
        out_last_next    = out_last_reg;
        rd_addr          = idx_reg[AW-1:0];

        if (acc)
        begin
            case (s_tuser)
                sarq_pkg::KIND_SEND:
                begin
                    if (!waiting_reg)
                    begin
                        if (tx_length_reg < LEN_MAX)
                        begin
                            mem_we         = 1'b1;
                            tx_length_next = tx_length_reg + LW'(1);
                        end
                        if (s_tlast)
                        begin
                            tx_command_next = in_cmd;
                            waiting_next    = 1'b1;
                            frame_req       = 1'b1;
                            if (in_cmd == msg_command_reg)
                            begin
                                timer_armed_next = 1'b1;
                                timer_count_next = '0;
                            end
                        end
                    end
                end
                sarq_pkg::KIND_RX:
                begin
                    if (rx_phase_reg == sarq_pkg::RX_DELIVER)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = sarq_pkg::OUT_DELIVER;
                        out_byte_next  = in_byte;
                        out_cmd_next   = in_cmd;
                        out_last_next  = s_tlast;
                        if (s_tlast)
                        begin
                            rx_phase_next = sarq_pkg::RX_CTRL;
                        end
                    end
                    else if (rx_phase_reg != sarq_pkg::RX_CTRL)
                    begin
                        if (s_tlast)
                        begin
                            rx_phase_next = sarq_pkg::RX_CTRL;
                        end
                    end
                    else
                    begin
                        // Control byte: matching ack, wrong ack, new data, old data
                        if (!s_tlast)
                        begin
                            rx_phase_next = sarq_pkg::RX_DISCARD;
                        end
                        if (waiting_reg && in_byte == good_ack)
                        begin
                            tx_seq_next      = !tx_seq_reg;
                            waiting_next     = 1'b0;
                            retry_count_next = '0;
                            timer_armed_next = 1'b0;
                            timer_count_next = '0;
                            tx_length_next   = '0;
                            out_valid_next   = 1'b1;
                            out_kind_next    = sarq_pkg::OUT_ACKED;
                            out_byte_next    = '0;
                            out_cmd_next     = '0;
                            out_last_next    = 1'b1;
                        end
                        else if (waiting_reg && in_byte == bad_ack)
                        begin
                            if (retry_count_reg < max_retries_reg)
                            begin
                                frame_req        = 1'b1;
                                retry_count_next = retry_count_reg + 4'd1;
                                timer_armed_next = 1'b1;
                                timer_count_next = '0;
                            end
                            else
                            begin
                                timer_armed_next = 1'b0;
                                timer_count_next = '0;
                                waiting_next     = 1'b0;
                                retry_count_next = '0;
                                tx_length_next   = '0;
                                out_valid_next   = 1'b1;
                                out_kind_next    = sarq_pkg::OUT_GAVE_UP;
                                out_byte_next    = '0;
                                out_cmd_next     = '0;
                                out_last_next    = 1'b1;
                            end
                        end
                        else if (in_byte == new_data)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = sarq_pkg::OUT_FRAME;
                            out_byte_next  = rx_seq_reg ? ack1_code_reg : ack0_code_reg;
                            out_cmd_next   = in_cmd;
                            out_last_next  = 1'b1;
                            rx_seq_next    = !rx_seq_reg;
                            if (!s_tlast)
                            begin
                                rx_phase_next = sarq_pkg::RX_DELIVER;
                            end
                        end
                        else if (in_byte == old_data)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = sarq_pkg::OUT_FRAME;
                            out_byte_next  = rx_seq_reg ? ack0_code_reg : ack1_code_reg;
                            out_cmd_next   = in_cmd;
                            out_last_next  = 1'b1;
                        end
                    end
                end
                sarq_pkg::KIND_TICK:
                begin
                    if (timer_armed_reg)
                    begin
                        timer_count_next = cnt_inc;
                        if (cnt_inc >= timeout_ticks_reg)
                        begin
                            timer_armed_next = 1'b0;
                            timer_count_next = '0;
                            if (waiting_reg)
                            begin
                                if (retry_count_reg < max_retries_reg)
                                begin
                                    frame_req        = 1'b1;
                                    retry_count_next = retry_count_reg + 4'd1;
                                    timer_armed_next = 1'b1;
                                end
                                else
                                begin
                                    waiting_next     = 1'b0;
                                    retry_count_next = '0;
                                    tx_length_next   = '0;
                                    out_valid_next   = 1'b1;
                                    out_kind_next    = sarq_pkg::OUT_GAVE_UP;
                                    out_byte_next    = '0;
                                    out_cmd_next     = '0;
                                    out_last_next    = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Send the control byte of the frame
        if (cmd.emit_ctrl)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = sarq_pkg::OUT_FRAME;
            out_byte_next  = tx_seq_reg ? sarq_pkg::DATA1_CODE : sarq_pkg::DATA0_CODE;
            out_cmd_next   = tx_command_reg;
            out_last_next  = (tx_length_reg == '0);
        end

        // Send one payload byte and fetch the next
        if (cmd.emit_data)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = sarq_pkg::OUT_FRAME;
            out_byte_next  = rd_data_reg;
            out_cmd_next   = tx_command_reg;
            out_last_next  = (idx_inc == tx_length_reg);
            rd_addr        = idx_inc[AW-1:0];
            idx_next       = (idx_inc == tx_length_reg) ? '0 : idx_inc;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg     <= 1'b0;
            tx_seq_reg      <= 1'b0;
            rx_seq_reg      <= 1'b0;
            retry_count_reg <= '0;
            timer_armed_reg <= 1'b0;
            timer_count_reg <= '0;
            tx_length_reg   <= '0;
            rx_phase_reg    <= sarq_pkg::RX_CTRL;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            waiting_reg     <= waiting_next;
            tx_seq_reg      <= tx_seq_next;
            rx_seq_reg      <= rx_seq_next;
            retry_count_reg <= retry_count_next;
            timer_armed_reg <= timer_armed_next;
            timer_count_reg <= timer_count_next;
            tx_length_reg   <= tx_length_next;
            rx_phase_reg    <= rx_phase_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        tx_command_reg <= tx_command_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_cmd_reg    <= out_cmd_next;
        out_last_reg   <= out_last_next;
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tx_length_reg[AW-1:0]] <= in_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/stop_and_wait_arq.sv =====
// Top level of the alternating-bit stop-and-wait ARQ block.
//
// Input stream (s_*): one item per transfer. s_tuser is the kind (send payload
// byte, received frame byte, timer tick), s_tdata carries the byte and the
// command, s_tlast marks the last byte of a send request or a received frame.
// Output stream (m_*): frame bytes down, payload bytes up, give-up and acked
// notices; m_tlast ends each frame, ack, delivery or notice.
// Configuration: cfg_we writes register cfg_index with cfg_data;
// write it only while the block is idle.
// Timing: a direct result appears on m_* in the cycle after the item that causes it;
// the control byte of a frame follows once the controller leaves idle and the output is free.
// Throughput: one item per cycle while the output is not stalled and its result
// (if any) is a single transfer. An item that starts a frame blocks the next item
// until the frame has left: the payload store has one read port, the frame leaves
// one byte per cycle while the output is not stalled, and s_tready stays low meanwhile.
// Output stall: a held result blocks the next transfer; s_tready is low while
// the output register is full and m_tready is low.
// Reset: all protocol state returns to idle, sequence bits clear, registers take
// their reset values; the payload store keeps its contents and needs no clearing.
`default_nettype none

module stop_and_wait_arq
#(
    parameter int MAX_PAYLOAD = sarq_pkg::MAX_PAYLOAD_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [7:0] data_byte, [15:8] command
    input  wire logic        s_tlast,
    input  wire logic [1:0]  s_tuser,    // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] out_byte, [15:8] out_command
    output logic             m_tlast,
    output logic [1:0]       m_tuser     // [1:0] out_kind
);

    sarq_pkg::sarq_cmd_t cmd;
    sarq_pkg::sarq_sts_t sts;

    sarq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    sarq_dp
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== design/sarq_check.sv =====
// Port-level checks of the stop-and-wait ARQ block and their binding.
`default_nettype none

module sarq_check
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Notices are single, empty transfers
    a_notice_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sarq_pkg::OUT_GAVE_UP || m_tuser == sarq_pkg::OUT_ACKED)
            |-> m_tlast && (m_tdata == 16'd0))
        else $error("notice with data or without last");

    // Input is taken only when the output register can take a result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while output full");

    // An item is never accepted while a result is stalled on the output
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid |-> m_tready)
        else $error("item taken over a stalled result");

endmodule

bind stop_and_wait_arq sarq_check u_sarq_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
